FILE: src/csr_spmv_pkg.sv
// Shared types, constants and helpers for the CSR sparse matrix engine.
package csr_spmv_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLS    = 256;
    localparam int DATA_WIDTH  = 32;
    localparam int ENT_AW      = 10;
    localparam int CNT_W       = 11;
    localparam int ROW_W       = 8;
    localparam int COL_W       = 8;
    localparam int VIDX_W      = 10;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int QDEPTH      = 2;

    typedef enum logic [2:0] {
        OP_TRIPLET = 3'd0,
        OP_VECTOR  = 3'd1,
        OP_QROW    = 3'd2,
        OP_QENTRY  = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 2'd0,
        CFG_NUM_COLS = 2'd1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_INS,
        BS_PUT,
        BS_RC_RD,
        BS_RC_WR,
        BS_QE,
        BS_PFX,
        BS_WALK
    } t_bstate;

    // Classified request handed from the front to the back.
    typedef struct packed {
        t_op                     op;
        logic                    bad;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic [DATA_WIDTH-1:0]   eval;
        logic [VIDX_W-1:0]       vidx;
        logic [DATA_WIDTH-1:0]   vval;
    } t_cmd;

    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic [DATA_WIDTH-1:0]   val;
    } t_entry;

    typedef struct packed {
        t_status                 status;
        logic [DATA_WIDTH-1:0]   row_sum;
        logic [CNT_W-1:0]        row_start;
        logic [CNT_W-1:0]        row_end;
        logic [DATA_WIDTH-1:0]   stored_value;
        logic [COL_W-1:0]        stored_col;
        logic [ROW_W-1:0]        stored_row;
    } t_result;

    // True when the stored entry sorts after the key (row, col).
    function automatic logic key_greater(t_entry e, logic [ROW_W-1:0] r,
                                         logic [COL_W-1:0] c);
        if (e.row != r) begin
            return e.row > r;
        end
        return e.col > c;
    endfunction

endpackage

FILE: src/csr_spmv_front.sv
// Front end: configuration registers and range classification of requests.
module csr_spmv_front import csr_spmv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic [2:0]            i_opcode,
    input  logic [ROW_W-1:0]      i_row_index,
    input  logic [COL_W-1:0]      i_col_index,
    input  logic [DATA_WIDTH-1:0] i_entry_value,
    input  logic [VIDX_W-1:0]     i_vector_index,
    input  logic [DATA_WIDTH-1:0] i_vector_value,
    output t_cmd                  o_cmd
);

    logic [CFG_W-1:0] r_num_rows;
    logic [CFG_W-1:0] r_num_cols;
    logic             row_ok;
    logic             col_ok;
    logic             vidx_ok;

    // Configuration registers; the write channel is always ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= CFG_W'(MAX_ROWS);
            r_num_cols <= CFG_W'(MAX_COLS);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_NUM_ROWS) begin
                r_num_rows <= i_cfg_data;
            end else if (i_cfg_index == CFG_NUM_COLS) begin
                r_num_cols <= i_cfg_data;
            end
        end
    end

    // Index checks against the configured matrix size.
    assign row_ok  = {1'b0, i_row_index} < r_num_rows;
    assign col_ok  = {1'b0, i_col_index} < r_num_cols;
    assign vidx_ok = (i_vector_index < {1'b0, r_num_cols}) &&
                     (i_vector_index < VIDX_W'(MAX_COLS));

    // Classify the request; unused opcodes become a failed clear.
    always_comb begin
        o_cmd.row  = i_row_index;
        o_cmd.col  = i_col_index;
        o_cmd.eval = i_entry_value;
        o_cmd.vidx = i_vector_index;
        o_cmd.vval = i_vector_value;
        o_cmd.op   = OP_CLEAR;
        o_cmd.bad  = 1'b1;
        unique case (i_opcode)
            OP_TRIPLET: begin
                o_cmd.op  = OP_TRIPLET;
                o_cmd.bad = !(row_ok && col_ok);
            end
            OP_VECTOR: begin
                o_cmd.op  = OP_VECTOR;
                o_cmd.bad = !vidx_ok;
            end
            OP_QROW: begin
                o_cmd.op  = OP_QROW;
                o_cmd.bad = !row_ok;
            end
            OP_QENTRY: begin
                o_cmd.op  = OP_QENTRY;
                o_cmd.bad = 1'b0;
            end
            OP_CLEAR: begin
                o_cmd.op  = OP_CLEAR;
                o_cmd.bad = 1'b0;
            end
            default: begin
                o_cmd.op  = OP_CLEAR;
                o_cmd.bad = 1'b1;
            end
        endcase
    end

endmodule

FILE: src/csr_spmv_queue.sv
// Two-entry request queue between the front and the back.
module csr_spmv_queue import csr_spmv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    t_cmd       r_mem [QDEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_cnt == 2'(QDEPTH);
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

FILE: src/csr_spmv_back.sv
// Back end: entry table, row counts, vector store and the request sequencer.
module csr_spmv_back import csr_spmv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_empty,
    output logic    o_cmd_pop,
    input  logic    i_res_pop,
    output logic    o_res_valid,
    output t_result o_res
);

    // Memories and their registered read data.
    t_entry                ent_mem [MAX_ENTRIES];
    logic [CNT_W-1:0]      rc_mem  [MAX_ROWS];
    logic [DATA_WIDTH-1:0] x_mem   [MAX_COLS];
    logic [MAX_ROWS-1:0]   r_rc_vld;
    t_entry                r_ent_rd;
    logic [CNT_W-1:0]      r_rc_rd;
    logic                  r_rc_rdv;
    logic [DATA_WIDTH-1:0] r_x_rd;

    logic                  ent_we;
    logic [ENT_AW-1:0]     ent_wa;
    t_entry                ent_wd;
    logic [ENT_AW-1:0]     ent_ra;
    logic                  rc_we;
    logic [ROW_W-1:0]      rc_wa;
    logic [CNT_W-1:0]      rc_wd;
    logic [ROW_W-1:0]      rc_ra;
    logic                  rc_clr;
    logic                  x_we;
    logic [COL_W-1:0]      x_wa;
    logic [COL_W-1:0]      x_ra;
    logic [CNT_W-1:0]      rc_val;
    logic [CNT_W:0]        tot;
    t_entry                new_ent;
    logic                  r_xw;

    // Sequencer state.
    t_bstate               r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [ENT_AW-1:0]     r_j, n_j;
    logic [CNT_W-1:0]      r_k, n_k;
    logic [CNT_W-1:0]      r_start, n_start;
    logic [CNT_W-1:0]      r_end, n_end;
    logic [DATA_WIDTH-1:0] r_sum, n_sum;
    logic                  r_pv, n_pv;
    logic [ROW_W-1:0]      r_pidx, n_pidx;
    logic                  r_v1, n_v1;
    logic                  r_v2, n_v2;
    logic                  r_v3, n_v3;
    logic [DATA_WIDTH-1:0] r_val2, n_val2;
    logic [DATA_WIDTH-1:0] r_prod, n_prod;
    t_result               r_res, n_res;
    logic                  r_res_valid, n_res_valid;

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign rc_val      = r_rc_rdv ? r_rc_rd : '0;
    assign new_ent     = '{row: r_cmd.row, col: r_cmd.col, val: r_cmd.eval};

    // Entry table.
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_wa] <= ent_wd;
        end
        r_ent_rd <= ent_mem[ent_ra];
    end

    // Row counts; an entry without its valid bit reads as zero.
    always_ff @(posedge i_clk) begin
        if (rc_we) begin
            rc_mem[rc_wa] <= rc_wd;
        end
        r_rc_rd <= rc_mem[rc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc_vld <= '0;
            r_rc_rdv <= 1'b0;
        end else begin
            r_rc_rdv <= r_rc_vld[rc_ra];
            if (rc_clr) begin
                r_rc_vld <= '0;
            end else if (rc_we) begin
                r_rc_vld[rc_wa] <= 1'b1;
            end
        end
    end

    // Vector store.
    always_ff @(posedge i_clk) begin
        if (x_we) begin
            x_mem[x_wa] <= r_cmd.vval;
        end
        r_x_rd <= x_mem[x_ra];
    end

    // Vector write strobe: set when a good vector load leaves the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xw <= 1'b0;
        end else begin
            r_xw <= o_cmd_pop && !i_cmd.bad && i_cmd.op == OP_VECTOR;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
            r_pv        <= n_pv;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_v3        <= n_v3;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_j     <= n_j;
        r_k     <= n_k;
        r_start <= n_start;
        r_end   <= n_end;
        r_sum   <= n_sum;
        r_pidx  <= n_pidx;
        r_val2  <= n_val2;
        r_prod  <= n_prod;
        r_res   <= n_res;
    end

    // Next state and memory controls.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_j         = r_j;
        n_k         = r_k;
        n_start     = r_start;
        n_end       = r_end;
        n_sum       = r_sum;
        n_pv        = 1'b0;
        n_pidx      = r_pidx;
        n_v1        = 1'b0;
        n_v2        = 1'b0;
        n_v3        = 1'b0;
        n_val2      = r_val2;
        n_prod      = r_prod;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_pop;
        o_cmd_pop   = 1'b0;
        ent_we      = 1'b0;
        ent_wa      = '0;
        ent_wd      = new_ent;
        ent_ra      = '0;
        rc_we       = 1'b0;
        rc_wa       = r_cmd.row;
        rc_wd       = rc_val + CNT_W'(1);
        rc_ra       = r_cmd.row;
        rc_clr      = 1'b0;
        // A vector load writes the latched request the cycle after it is taken.
        x_we        = r_xw;
        x_wa        = r_cmd.vidx[COL_W-1:0];
        x_ra        = r_ent_rd.col;
        tot         = {1'b0, r_start} + {1'b0, rc_val};

        unique case (r_state)
            BS_IDLE: begin
                // Take a new request only once the result slot is free.
                if (!r_res_valid && !i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_res     = '0;
                    if (i_cmd.bad) begin
                        n_res.status = ST_RANGE;
                        n_res_valid  = 1'b1;
                    end else begin
                        unique case (i_cmd.op)
                            OP_TRIPLET: begin
                                if (r_count == CNT_W'(MAX_ENTRIES)) begin
                                    n_res.status = ST_FULL;
                                    n_res_valid  = 1'b1;
                                end else if (r_count == '0) begin
                                    ent_we  = 1'b1;
                                    ent_wd  = '{row: i_cmd.row, col: i_cmd.col,
                                                val: i_cmd.eval};
                                    n_state = BS_RC_RD;
                                end else begin
                                    ent_ra  = ENT_AW'(r_count - CNT_W'(1));
                                    n_j     = ENT_AW'(r_count - CNT_W'(1));
                                    n_state = BS_INS;
                                end
                            end
                            OP_VECTOR: begin
                                n_state = BS_IDLE;
                                n_res.status = ST_OK;
                                n_res_valid  = 1'b1;
                            end
                            OP_QROW: begin
                                n_k     = '0;
                                n_start = '0;
                                n_state = BS_PFX;
                            end
                            OP_QENTRY: begin
                                if ({1'b0, i_cmd.vidx} >= r_count) begin
                                    n_res.status = ST_RANGE;
                                    n_res_valid  = 1'b1;
                                end else begin
                                    ent_ra  = i_cmd.vidx;
                                    n_state = BS_QE;
                                end
                            end
                            OP_CLEAR: begin
                                n_count      = '0;
                                rc_clr       = 1'b1;
                                n_res.status = ST_OK;
                                n_res_valid  = 1'b1;
                            end
                            default: begin
                                n_res.status = ST_RANGE;
                                n_res_valid  = 1'b1;
                            end
                        endcase
                    end
                end
            end
            BS_INS: begin
                // Shift larger keys up one slot, one entry per cycle.
                if (key_greater(r_ent_rd, r_cmd.row, r_cmd.col)) begin
                    ent_we = 1'b1;
                    ent_wa = r_j + ENT_AW'(1);
                    ent_wd = r_ent_rd;
                    if (r_j == '0) begin
                        n_state = BS_PUT;
                    end else begin
                        ent_ra = r_j - ENT_AW'(1);
                        n_j    = r_j - ENT_AW'(1);
                    end
                end else begin
                    ent_we  = 1'b1;
                    ent_wa  = r_j + ENT_AW'(1);
                    n_state = BS_RC_RD;
                end
            end
            BS_PUT: begin
                ent_we  = 1'b1;
                n_state = BS_RC_RD;
            end
            BS_RC_RD: begin
                n_state = BS_RC_WR;
            end
            BS_RC_WR: begin
                rc_we        = 1'b1;
                n_count      = r_count + CNT_W'(1);
                n_res.status = ST_OK;
                n_res_valid  = 1'b1;
                n_state      = BS_IDLE;
            end
            BS_QE: begin
                n_res.status       = ST_OK;
                n_res.stored_value = r_ent_rd.val;
                n_res.stored_col   = r_ent_rd.col;
                n_res.stored_row   = r_ent_rd.row;
                n_res_valid        = 1'b1;
                n_state            = BS_IDLE;
            end
            BS_PFX: begin
                // Prefix sum of row counts, one row read per cycle.
                rc_ra  = r_k[ROW_W-1:0];
                n_pidx = r_k[ROW_W-1:0];
                n_pv   = 1'b1;
                if (r_k[ROW_W-1:0] != r_cmd.row) begin
                    n_k = r_k + CNT_W'(1);
                end
                if (r_pv) begin
                    if (r_pidx == r_cmd.row) begin
                        n_end   = (tot > {1'b0, r_count}) ? r_count : tot[CNT_W-1:0];
                        n_k     = r_start;
                        n_sum   = '0;
                        n_state = BS_WALK;
                    end else begin
                        n_start = r_start + rc_val;
                    end
                end
            end
            BS_WALK: begin
                // Pipeline: entry read, x read, multiply, accumulate.
                if (r_k < r_end) begin
                    ent_ra = r_k[ENT_AW-1:0];
                    n_k    = r_k + CNT_W'(1);
                    n_v1   = 1'b1;
                end
                if (r_v1) begin
                    n_val2 = r_ent_rd.val;
                    n_v2   = 1'b1;
                end
                if (r_v2) begin
                    n_prod = r_val2 * r_x_rd;
                    n_v3   = 1'b1;
                end
                if (r_v3) begin
                    n_sum = r_sum + r_prod;
                end
                if (r_k >= r_end && !r_v1 && !r_v2 && !r_v3) begin
                    n_res.status    = ST_OK;
                    n_res.row_sum   = r_sum;
                    n_res.row_start = r_start;
                    n_res.row_end   = r_end;
                    n_res_valid     = 1'b1;
                    n_state         = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

endmodule

FILE: src/csr_build_and_spmv.sv
// Top level of the CSR sparse matrix engine: front, request queue and back.
// Flow after a push is accepted: a vector load, clear or failed request is answered directly;
// a triplet insert shifts larger entries up, then updates its row count; an entry query reads the table.
// Row query: a row-count prefix sum up to the row, then a walk over the row's entries.
// Throughput: one request at a time; the next is taken the cycle after a result is popped.
// Reset is synchronous: entry count and row-count valid bits clear at once.
module csr_build_and_spmv import csr_spmv_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [2:0]                   i_opcode,
    input  logic [ROW_W-1:0]             i_row_index,
    input  logic [COL_W-1:0]             i_col_index,
    input  logic signed [DATA_WIDTH-1:0] i_entry_value,
    input  logic [VIDX_W-1:0]            i_vector_index,
    input  logic signed [DATA_WIDTH-1:0] i_vector_value,
    output logic                         empty,
    input  logic                         pop,
    output logic [1:0]                   o_status,
    output logic signed [DATA_WIDTH-1:0] o_row_sum,
    output logic [CNT_W-1:0]             o_row_start,
    output logic [CNT_W-1:0]             o_row_end,
    output logic signed [DATA_WIDTH-1:0] o_stored_value,
    output logic [COL_W-1:0]             o_stored_col,
    output logic [ROW_W-1:0]             o_stored_row
);

    t_cmd    front_cmd;
    t_cmd    q_cmd;
    logic    q_empty;
    logic    q_pop;
    logic    res_valid;
    t_result res;

    assign o_cfg_ready = 1'b1;

    csr_spmv_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_row_index    (i_row_index),
        .i_col_index    (i_col_index),
        .i_entry_value  (i_entry_value),
        .i_vector_index (i_vector_index),
        .i_vector_value (i_vector_value),
        .o_cmd          (front_cmd)
    );

    csr_spmv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_cmd)
    );

    csr_spmv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .i_res_pop   (pop),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result ports.
    assign empty          = !res_valid;
    assign o_status       = res.status;
    assign o_row_sum      = res.row_sum;
    assign o_row_start    = res.row_start;
    assign o_row_end      = res.row_end;
    assign o_stored_value = res.stored_value;
    assign o_stored_col   = res.stored_col;
    assign o_stored_row   = res.stored_row;

endmodule

FILE: src/csr_spmv_chk.sv
// Port-level checker for the CSR sparse matrix engine, bound to the top level.
module csr_spmv_chk import csr_spmv_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_W-1:0]      i_cfg_data,
    input logic                  push,
    input logic                  full,
    input logic [2:0]            i_opcode,
    input logic [ROW_W-1:0]      i_row_index,
    input logic [COL_W-1:0]      i_col_index,
    input logic [DATA_WIDTH-1:0] i_entry_value,
    input logic [VIDX_W-1:0]     i_vector_index,
    input logic [DATA_WIDTH-1:0] i_vector_value,
    input logic                  empty,
    input logic                  pop,
    input logic [1:0]            o_status,
    input logic [DATA_WIDTH-1:0] o_row_sum,
    input logic [CNT_W-1:0]      o_row_start,
    input logic [CNT_W-1:0]      o_row_end,
    input logic [DATA_WIDTH-1:0] o_stored_value,
    input logic [COL_W-1:0]      o_stored_col,
    input logic [ROW_W-1:0]      o_stored_row
);

    // A waiting result stays until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped before pop");

    // A waiting result keeps its status.
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_status))
        else $error("waiting result changed");

    // A failed request carries zero payload.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status != ST_OK |->
            o_row_sum == '0 && o_row_end == '0 && o_stored_value == '0)
        else $error("failed request with nonzero payload");

    // CSR pointers never run backwards.
    a_ptr_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_row_end >= o_row_start)
        else $error("row end below row start");

endmodule

bind csr_build_and_spmv csr_spmv_chk u_chk (.*);

FILE: tb/csr_build_and_spmv_tb.sv
// Self-checking testbench for the CSR sparse matrix engine with its own prediction.
`timescale 1ns / 100ps

module csr_build_and_spmv_tb;
    import csr_spmv_pkg::*;

    typedef struct {
        logic [2:0]            op;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic [DATA_WIDTH-1:0] eval;
        logic [VIDX_W-1:0]     vidx;
        logic [DATA_WIDTH-1:0] vval;
    } t_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [2:0]            i_opcode = '0;
    logic [ROW_W-1:0]      i_row_index = '0;
    logic [COL_W-1:0]      i_col_index = '0;
    logic [DATA_WIDTH-1:0] i_entry_value = '0;
    logic [VIDX_W-1:0]     i_vector_index = '0;
    logic [DATA_WIDTH-1:0] i_vector_value = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [1:0]            o_status;
    logic [DATA_WIDTH-1:0] o_row_sum;
    logic [CNT_W-1:0]      o_row_start;
    logic [CNT_W-1:0]      o_row_end;
    logic [DATA_WIDTH-1:0] o_stored_value;
    logic [COL_W-1:0]      o_stored_col;
    logic [ROW_W-1:0]      o_stored_row;

    csr_build_and_spmv DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_opcode(i_opcode), .i_row_index(i_row_index), .i_col_index(i_col_index),
        .i_entry_value(i_entry_value), .i_vector_index(i_vector_index),
        .i_vector_value(i_vector_value),
        .empty(empty), .pop(pop),
        .o_status(o_status), .o_row_sum(o_row_sum), .o_row_start(o_row_start),
        .o_row_end(o_row_end), .o_stored_value(o_stored_value),
        .o_stored_col(o_stored_col), .o_stored_row(o_stored_row)
    );

    // Clock: 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the engine state.
    logic [ROW_W-1:0]      tbl_row [MAX_ENTRIES];
    logic [COL_W-1:0]      tbl_col [MAX_ENTRIES];
    logic [DATA_WIDTH-1:0] tbl_val [MAX_ENTRIES];
    int unsigned           tbl_count;
    int unsigned           row_cnt [MAX_ROWS];
    logic [DATA_WIDTH-1:0] x_vals [MAX_COLS];
    int unsigned           lim_rows = 256;
    int unsigned           lim_cols = 256;

    t_req    pending_reqs[$];
    t_result answer_q[$];
    int      mismatches = 0;
    int      n_accepted = 0;
    int      n_answers = 0;
    int      n_full = 0;
    int      n_range = 0;

    // Stimulus-side tracking, so that no row query touches an unloaded x element.
    bit          x_loaded [MAX_COLS];
    int unsigned gen_rows = 256;
    int unsigned gen_cols = 256;
    int unsigned gen_count = 0;

    // Apply one request to the shadow state and return the answer it must give.
    function automatic t_result engine_step(t_req q);
        t_result     res;
        int unsigned pos, start, stop;
        logic [DATA_WIDTH-1:0] acc;
        res = '0;
        res.status = ST_OK;
        case (q.op)
            OP_TRIPLET: begin
                if (q.row >= lim_rows || q.col >= lim_cols) begin
                    res.status = ST_RANGE;
                end else if (tbl_count >= MAX_ENTRIES) begin
                    res.status = ST_FULL;
                end else begin
                    pos = tbl_count;
                    while (pos > 0 && (tbl_row[pos-1] > q.row ||
                           (tbl_row[pos-1] == q.row && tbl_col[pos-1] > q.col))) begin
                        tbl_row[pos] = tbl_row[pos-1];
                        tbl_col[pos] = tbl_col[pos-1];
                        tbl_val[pos] = tbl_val[pos-1];
                        pos--;
                    end
                    tbl_row[pos] = q.row;
                    tbl_col[pos] = q.col;
                    tbl_val[pos] = q.eval;
                    tbl_count++;
                    row_cnt[q.row]++;
                end
            end
            OP_VECTOR: begin
                if (q.vidx >= lim_cols || q.vidx >= MAX_COLS) res.status = ST_RANGE;
                else x_vals[q.vidx] = q.vval;
            end
            OP_QROW: begin
                if (q.row >= lim_rows) begin
                    res.status = ST_RANGE;
                end else begin
                    start = 0;
                    for (int k = 0; k < q.row; k++) start += row_cnt[k];
                    stop = start + row_cnt[q.row];
                    if (stop > tbl_count) stop = tbl_count;
                    acc = '0;
                    for (int k = start; k < stop; k++) acc += tbl_val[k] * x_vals[tbl_col[k]];
                    res.row_sum = acc;
                    res.row_start = start[CNT_W-1:0];
                    res.row_end = stop[CNT_W-1:0];
                end
            end
            OP_QENTRY: begin
                if (q.vidx >= tbl_count) begin
                    res.status = ST_RANGE;
                end else begin
                    res.stored_value = tbl_val[q.vidx];
                    res.stored_col = tbl_col[q.vidx];
                    res.stored_row = tbl_row[q.vidx];
                end
            end
            OP_CLEAR: begin
                tbl_count = 0;
                foreach (row_cnt[k]) row_cnt[k] = 0;
            end
            default: res.status = ST_RANGE;
        endcase
        return res;
    endfunction

    // Driver: bursts of requests separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                answer_q.push_back(engine_step(pending_reqs[0]));
                void'(pending_reqs.pop_front());
                n_accepted++;
            end
            if (!(push && full)) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    burst_left--;
                    push <= 1'b1;
                    i_opcode <= pending_reqs[0].op;
                    i_row_index <= pending_reqs[0].row;
                    i_col_index <= pending_reqs[0].col;
                    i_entry_value <= pending_reqs[0].eval;
                    i_vector_index <= pending_reqs[0].vidx;
                    i_vector_value <= pending_reqs[0].vval;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: pops on a changing stall pattern and checks each answer.
    int stall_mode = 0;
    int stall_cnt = 0;
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got.status = t_status'(o_status);
                got.row_sum = o_row_sum;
                got.row_start = o_row_start;
                got.row_end = o_row_end;
                got.stored_value = o_stored_value;
                got.stored_col = o_stored_col;
                got.stored_row = o_stored_row;
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result, status %0d", o_status);
                end else begin
                    want = answer_q.pop_front();
                    n_answers++;
                    if (want.status == ST_FULL) n_full++;
                    if (want.status == ST_RANGE) n_range++;
                    if (got.status !== want.status || got.row_sum !== want.row_sum ||
                        got.row_start !== want.row_start || got.row_end !== want.row_end ||
                        got.stored_value !== want.stored_value ||
                        got.stored_col !== want.stored_col ||
                        got.stored_row !== want.stored_row) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d mismatch: status %0d/%0d sum %h/%h",
                                     n_answers, want.status, got.status,
                                     want.row_sum, got.row_sum);
                            $display("  start %0d/%0d end %0d/%0d val %h/%h",
                                     want.row_start, got.row_start, want.row_end, got.row_end,
                                     want.stored_value, got.stored_value);
                            $display("  col %0d/%0d row %0d/%0d",
                                     want.stored_col, got.stored_col,
                                     want.stored_row, got.stored_row);
                        end
                    end
                end
            end
            if (stall_cnt == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_cnt = $urandom_range(16, 96);
            end
            stall_cnt--;
            case (stall_mode)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 3) != 0);
                default: pop <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Queue one request.
    task automatic add_req(logic [2:0] op, int r, int c, logic [31:0] ev, int vi,
                           logic [31:0] vv);
        t_req q;
        q.op = op;
        q.row = r[ROW_W-1:0];
        q.col = c[COL_W-1:0];
        q.eval = ev;
        q.vidx = vi[VIDX_W-1:0];
        q.vval = vv;
        pending_reqs.push_back(q);
        if (op == OP_VECTOR && vi < gen_cols && vi < MAX_COLS) x_loaded[vi] = 1'b1;
        if (op == OP_TRIPLET && r < gen_rows && c < gen_cols) gen_count++;
        if (op == OP_CLEAR) gen_count = 0;
    endtask

    // Queue a triplet, loading its x element first where it would be stored.
    task automatic add_triplet(int r, int c, logic [31:0] ev);
        if (r < gen_rows && c < gen_cols && !x_loaded[c])
            add_req(OP_VECTOR, 0, 0, '0, c, $urandom());
        add_req(OP_TRIPLET, r, c, ev, $urandom_range(0, 1023), $urandom());
    endtask

    // Wait until every request is answered, plus settling time.
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || answer_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write one configuration register while the engine is idle.
    task automatic cfg_write(t_cfg_idx idx, int unsigned data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data[CFG_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_NUM_ROWS) begin
            lim_rows = data;
            gen_rows = data;
        end else begin
            lim_cols = data;
            gen_cols = data;
        end
        @(posedge i_clk);
    endtask

    // Random traffic, biased toward valid triplets and queries.
    task automatic random_traffic(int n);
        int sel, r, c;
        logic [31:0] v;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(0, gen_rows - 1);
            c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(0, gen_cols - 1);
            v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) - 8 : $urandom();
            if (sel < 38) begin
                add_triplet(r, c, v);
            end else if (sel < 50) begin
                add_req(OP_VECTOR, r, c, v,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : c,
                        $urandom());
            end else if (sel < 75) begin
                add_req(OP_QROW, r, c, v, $urandom_range(0, 1023), $urandom());
            end else if (sel < 92) begin
                add_req(OP_QENTRY, r, c, v,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, gen_count + 1),
                        $urandom());
            end else if (sel < 95) begin
                add_req(OP_CLEAR, r, c, v, $urandom_range(0, 1023), $urandom());
            end else begin
                add_req(3'($urandom_range(5, 7)), r, c, v, $urandom_range(0, 1023),
                        $urandom());
            end
        end
    endtask

    // Stimulus: directed cases, then random phases over several settings.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, equal keys, empty rows, bad indexes and opcodes.
        add_req(OP_VECTOR, 0, 0, '0, 0, 32'h8000_0000);
        add_req(OP_VECTOR, 0, 0, '0, 255, 32'h7fff_ffff);
        add_triplet(255, 255, 32'h7fff_ffff);
        add_triplet(0, 0, 32'h8000_0000);
        add_triplet(0, 255, 32'hffff_ffff);
        add_triplet(5, 7, 32'd1);
        add_triplet(5, 7, 32'd2);
        add_req(OP_QROW, 0, 0, '0, 0, '0);
        add_req(OP_QROW, 255, 0, '0, 0, '0);
        add_req(OP_QROW, 5, 0, '0, 0, '0);
        add_req(OP_QROW, 3, 0, '0, 0, '0);
        add_req(OP_QENTRY, 0, 0, '0, 0, '0);
        add_req(OP_QENTRY, 0, 0, '0, 2, '0);
        add_req(OP_QENTRY, 0, 0, '0, 3, '0);
        add_req(OP_QENTRY, 0, 0, '0, 5, '0);
        add_req(OP_QENTRY, 0, 0, '0, 1023, '0);
        add_req(OP_VECTOR, 0, 0, '0, 256, 32'h1);
        add_req(OP_VECTOR, 0, 0, '0, 1023, 32'h1);
        add_req(3'd5, 0, 0, '0, 0, '0);
        add_req(3'd6, 0, 0, '0, 0, '0);
        add_req(3'd7, 255, 255, 32'hffff_ffff, 1023, 32'hffff_ffff);
        add_req(OP_CLEAR, 0, 0, '0, 0, '0);
        add_req(OP_QROW, 255, 0, '0, 0, '0);
        add_req(OP_QENTRY, 0, 0, '0, 0, '0);
        wait_drained();

        // Random phases over several register settings.
        cfg_write(CFG_NUM_ROWS, 256);
        cfg_write(CFG_NUM_COLS, 256);
        random_traffic(150);
        wait_drained();
        cfg_write(CFG_NUM_ROWS, 16);
        cfg_write(CFG_NUM_COLS, 40);
        random_traffic(120);
        wait_drained();
        cfg_write(CFG_NUM_ROWS, 1);
        cfg_write(CFG_NUM_COLS, 1);
        random_traffic(60);
        wait_drained();
        cfg_write(CFG_NUM_ROWS, 0);
        cfg_write(CFG_NUM_COLS, 0);
        random_traffic(20);
        wait_drained();
        cfg_write(CFG_NUM_ROWS, 200);
        cfg_write(CFG_NUM_COLS, 256);
        random_traffic(80);
        wait_drained();

        // Full row range again: queries around a clear, then more traffic.
        cfg_write(CFG_NUM_ROWS, 256);
        add_req(OP_CLEAR, 0, 0, '0, 0, '0);
        add_triplet(10, 2, 32'h5);
        add_req(OP_TRIPLET, 255, 255, 32'h5, 0, '0);
        add_req(OP_QROW, 255, 0, '0, 0, '0);
        add_req(OP_QROW, 100, 0, '0, 0, '0);
        add_req(OP_QENTRY, 0, 0, '0, 1023, '0);
        add_req(OP_QENTRY, 0, 0, '0, 1, '0);
        add_req(OP_CLEAR, 0, 0, '0, 0, '0);
        add_req(OP_QENTRY, 0, 0, '0, 0, '0);
        random_traffic(40);
        wait_drained();
        repeat (50) @(posedge i_clk);

        $display("Covered %0d requests and %0d answers (%0d table full, %0d out of range),",
                 n_accepted, n_answers, n_full, n_range);
        $display("over six register settings including zero, one and full size.");
        if (mismatches == 0) begin
            $display("csr_build_and_spmv_tb: done, clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("csr_build_and_spmv_tb: done, errors");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #200_000_000;
        $display("timeout, %0d requests still pending", pending_reqs.size());
        $display("csr_build_and_spmv_tb: done, errors");
        $finish;
    end

endmodule
